[rtl/wbpt_pkg.sv]
// Shared types, codes and constants for the work/break phase timer.
// No dependencies; every other file imports this package.
package wbpt_pkg;

  // Field widths
  localparam int REQ_W   = 3;
  localparam int TIME_W  = 32;
  localparam int PHASE_W = 2;
  localparam int INDEX_W = 8;
  localparam int SEC_W   = 14;
  localparam int MIN_W   = 8;
  localparam int CYC_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START_PAUSE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESET       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RELOAD      = 3'd4;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_WORK  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SHORT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORK_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE     = 2'd3;

  // Reset values of the duration registers
  localparam logic [MIN_W-1:0] WORK_MIN_RST  = 8'd25;
  localparam logic [MIN_W-1:0] SHORT_MIN_RST = 8'd5;
  localparam logic [MIN_W-1:0] LONG_MIN_RST  = 8'd15;
  localparam logic [CYC_W-1:0] CYCLE_RST     = 4'd4;

  // Timing constants
  localparam int SAVE_PERIOD_MS = 15 * 1000;
  localparam int ROUND_UP_MS    = 999;
  localparam int MS_PER_SEC     = 1000;
  localparam int SEC_PER_MIN    = 60;
  localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

  // Result of the deadline-to-seconds conversion
  typedef struct packed {
    logic             expired;
    logic [SEC_W-1:0] secs;
  } wbpt_remain_t;

  // Phase length in seconds; an unused phase code counts as work
  function automatic logic [SEC_W-1:0] phase_secs(
    input logic [MIN_W-1:0]   work_min,
    input logic [MIN_W-1:0]   short_min,
    input logic [MIN_W-1:0]   long_min,
    input logic [PHASE_W-1:0] ph
  );
    logic [MIN_W-1:0] m;
    m = (ph == PH_SHORT) ? short_min : (ph == PH_LONG) ? long_min : work_min;
    return SEC_W'(m) * SEC_W'(SEC_PER_MIN);
  endfunction

endpackage

[rtl/wbpt_ifs.sv]
// Valid/ready channel interfaces of the work/break phase timer:
// request input, status result and configuration write. Uses wbpt_pkg.
interface wbpt_in_if import wbpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, req_type, now_ms, input ready);
  modport sink   (input valid, req_type, now_ms, output ready);
endinterface

interface wbpt_out_if import wbpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic [INDEX_W-1:0] session_index;
  logic [SEC_W-1:0]   seconds_left;
  logic               is_running;
  logic               is_done;
  logic               just_expired;
  logic               save_request;
  modport source (output valid, phase, session_index, seconds_left, is_running, is_done,
                  just_expired, save_request, input ready);
  modport sink   (input valid, phase, session_index, seconds_left, is_running, is_done,
                  just_expired, save_request, output ready);
endinterface

interface wbpt_cfg_if import wbpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MIN_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/wbpt_remain.sv]
// Deadline to remaining-seconds conversion: wrap-safe expiry test, round-up
// divide by 1000 through a reciprocal multiply, saturation. Uses wbpt_pkg.
module wbpt_remain import wbpt_pkg::*; (
  input  logic [TIME_W-1:0] deadline,
  input  logic [TIME_W-1:0] now_ms,
  output wbpt_remain_t      result
);

  // sum/1000 = (sum>>3)/125, sum < 16384000 so (sum>>3) fits 21 bits;
  // reciprocal ceil(2^28/125) has error 44 <= 2^(28-21), so the floor is exact.
  localparam int  DIV_SHIFT = 28;
  localparam int  Y_W       = 21;
  localparam int  PROD_W    = 43;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(((64'd1 << DIV_SHIFT) + 64'd124) / 64'd125);
  localparam logic [TIME_W-1:0] SAT_LIMIT = TIME_W'((SEC_MAX + 1) * MS_PER_SEC);

  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] sum;
  logic [Y_W-1:0]    y;
  logic [PROD_W-1:0] prod;

  // Wrap-safe distance to the deadline
  assign diff = deadline - now_ms;
  assign sum  = diff + TIME_W'(ROUND_UP_MS);
  assign y    = sum[Y_W+2:3];
  assign prod = PROD_W'(y) * RECIP;

  // Expired when the deadline is reached or lies behind
  assign result.expired = (diff == '0) || diff[TIME_W-1];
  assign result.secs    = (sum >= SAT_LIMIT) ? SEC_MAX : prod[DIV_SHIFT+SEC_W-1:DIV_SHIFT];

endmodule

[rtl/work_break_phase_timer.sv]
// Work/break phase countdown timer. One result per request, one request per
// clock while the output is taken: a request is held in the input register, its
// effect on the timer state and its status result are computed in a single pass
// and written to the output register, so each result passes through the input
// and output registers, and the output register holds its result until taken.
// The critical path is the deadline subtract, round-up reciprocal multiply and
// saturation compare feeding the state and result registers. Durations written
// through the configuration port take effect only on a reset or reload request.
// Uses wbpt_pkg, wbpt_ifs and wbpt_remain.
module work_break_phase_timer import wbpt_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  wbpt_in_if.sink     in_if,
  wbpt_out_if.source  out_if,
  wbpt_cfg_if.sink    cfg_if
);

  // Configuration registers
  logic [MIN_W-1:0] reg_work_r, reg_short_r, reg_long_r;
  logic [CYC_W-1:0] reg_cycle_r;

  // Timer state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic [SEC_W-1:0]   remain_r, remain_nxt;
  logic               running_r, running_nxt;
  logic               done_r, done_nxt;
  logic [TIME_W-1:0]  deadline_r, deadline_nxt;
  logic [TIME_W-1:0]  last_save_r, last_save_nxt;
  logic [MIN_W-1:0]   app_work_r, app_short_r, app_long_r;
  logic [MIN_W-1:0]   app_work_nxt, app_short_nxt, app_long_nxt;
  logic [CYC_W-1:0]   app_cycle_r, app_cycle_nxt;
  logic               expired_nxt, save_nxt;

  // Pipeline registers
  logic               s1_valid_r;
  logic [REQ_W-1:0]   s1_req_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               out_valid_r;
  logic [PHASE_W-1:0] out_phase_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [SEC_W-1:0]   out_secs_r;
  logic               out_running_r, out_done_r, out_expired_r, out_save_r;

  logic         advance;
  logic         process;
  wbpt_remain_t rem;
  logic [SEC_W-1:0]  old_dur;
  logic [TIME_W-1:0] run_ms;

  // Handshake: output register frees when empty or taken
  assign advance      = !out_valid_r || out_if.ready;
  assign process      = s1_valid_r && advance;
  assign in_if.ready  = !s1_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_work_r  <= WORK_MIN_RST;
      reg_short_r <= SHORT_MIN_RST;
      reg_long_r  <= LONG_MIN_RST;
      reg_cycle_r <= CYCLE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_WORK_MIN:  reg_work_r  <= cfg_if.data;
        CFG_SHORT_MIN: reg_short_r <= cfg_if.data;
        CFG_LONG_MIN:  reg_long_r  <= cfg_if.data;
        CFG_CYCLE:     reg_cycle_r <= cfg_if.data[CYC_W-1:0];
        default:       reg_cycle_r <= reg_cycle_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_req_r <= in_if.req_type;
      s1_now_r <= in_if.now_ms;
    end
  end

  // Remaining time from the armed deadline
  wbpt_remain u_remain (
    .deadline (deadline_r),
    .now_ms   (s1_now_r),
    .result   (rem)
  );

  assign old_dur = phase_secs(app_work_r, app_short_r, app_long_r, phase_r);
  assign run_ms  = s1_now_r + TIME_W'(24'(remain_r) * 24'(MS_PER_SEC));

  // Next state and result flags for the request in the input register
  always_comb begin
    phase_nxt     = phase_r;
    index_nxt     = index_r;
    remain_nxt    = remain_r;
    running_nxt   = running_r;
    done_nxt      = done_r;
    deadline_nxt  = deadline_r;
    last_save_nxt = last_save_r;
    app_work_nxt  = app_work_r;
    app_short_nxt = app_short_r;
    app_long_nxt  = app_long_r;
    app_cycle_nxt = app_cycle_r;
    expired_nxt   = 1'b0;
    save_nxt      = 1'b0;

    unique case (s1_req_r)
      REQ_TICK: begin
        if (running_r) begin
          if (rem.expired) begin
            remain_nxt  = '0;
            running_nxt = 1'b0;
            done_nxt    = 1'b1;
            expired_nxt = 1'b1;
            save_nxt    = 1'b1;
          end else begin
            remain_nxt = rem.secs;
            if ((s1_now_r - last_save_r) >= TIME_W'(SAVE_PERIOD_MS)) begin
              last_save_nxt = s1_now_r;
              save_nxt      = 1'b1;
            end
          end
        end
      end
      REQ_START_PAUSE: begin
        if (running_r) begin
          save_nxt    = 1'b1;
          running_nxt = 1'b0;
          if (rem.expired) begin
            remain_nxt = '0;
            done_nxt   = 1'b1;
          end else begin
            remain_nxt = rem.secs;
          end
        end else if (!done_r && remain_r != '0) begin
          deadline_nxt  = run_ms;
          last_save_nxt = s1_now_r;
          running_nxt   = 1'b1;
          save_nxt      = 1'b1;
        end
      end
      REQ_ADVANCE: begin
        unique case (phase_r)
          PH_WORK: begin
            phase_nxt = (index_r < INDEX_W'(app_cycle_r)) ? PH_SHORT : PH_LONG;
          end
          PH_SHORT: begin
            phase_nxt = PH_WORK;
            index_nxt = index_r + INDEX_W'(1);
          end
          default: begin
            phase_nxt = PH_WORK;
            index_nxt = INDEX_W'(1);
          end
        endcase
        remain_nxt    = phase_secs(app_work_r, app_short_r, app_long_r, phase_nxt);
        running_nxt   = 1'b0;
        done_nxt      = 1'b0;
        deadline_nxt  = '0;
        last_save_nxt = s1_now_r;
        save_nxt      = 1'b1;
      end
      REQ_RESET: begin
        app_work_nxt  = reg_work_r;
        app_short_nxt = reg_short_r;
        app_long_nxt  = reg_long_r;
        app_cycle_nxt = reg_cycle_r;
        phase_nxt     = PH_WORK;
        index_nxt     = INDEX_W'(1);
        remain_nxt    = phase_secs(reg_work_r, reg_short_r, reg_long_r, PH_WORK);
        running_nxt   = 1'b0;
        done_nxt      = 1'b0;
        deadline_nxt  = '0;
        last_save_nxt = s1_now_r;
        save_nxt      = 1'b1;
      end
      REQ_RELOAD: begin
        app_work_nxt  = reg_work_r;
        app_short_nxt = reg_short_r;
        app_long_nxt  = reg_long_r;
        app_cycle_nxt = reg_cycle_r;
        if (index_r > INDEX_W'(reg_cycle_r)) index_nxt = INDEX_W'(reg_cycle_r);
        // Untouched session picks up the new duration
        if (!running_r && !done_r && remain_r == old_dur) begin
          remain_nxt = phase_secs(reg_work_r, reg_short_r, reg_long_r, phase_r);
        end
        save_nxt = 1'b1;
      end
      default: begin
        save_nxt = 1'b0;
      end
    endcase
  end

  // Timer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WORK;
      index_r     <= INDEX_W'(1);
      remain_r    <= phase_secs(WORK_MIN_RST, SHORT_MIN_RST, LONG_MIN_RST, PH_WORK);
      running_r   <= 1'b0;
      done_r      <= 1'b0;
      deadline_r  <= '0;
      last_save_r <= '0;
      app_work_r  <= WORK_MIN_RST;
      app_short_r <= SHORT_MIN_RST;
      app_long_r  <= LONG_MIN_RST;
      app_cycle_r <= CYCLE_RST;
    end else if (process) begin
      phase_r     <= phase_nxt;
      index_r     <= index_nxt;
      remain_r    <= remain_nxt;
      running_r   <= running_nxt;
      done_r      <= done_nxt;
      deadline_r  <= deadline_nxt;
      last_save_r <= last_save_nxt;
      app_work_r  <= app_work_nxt;
      app_short_r <= app_short_nxt;
      app_long_r  <= app_long_nxt;
      app_cycle_r <= app_cycle_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_phase_r   <= phase_nxt;
      out_index_r   <= index_nxt;
      out_secs_r    <= remain_nxt;
      out_running_r <= running_nxt;
      out_done_r    <= done_nxt;
      out_expired_r <= expired_nxt;
      out_save_r    <= save_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.phase         = out_phase_r;
  assign out_if.session_index = out_index_r;
  assign out_if.seconds_left  = out_secs_r;
  assign out_if.is_running    = out_running_r;
  assign out_if.is_done       = out_done_r;
  assign out_if.just_expired  = out_expired_r;
  assign out_if.save_request  = out_save_r;

  // A finished phase is never armed and shows no time left
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!running_r && remain_r == '0))
    else $error("done phase still armed or has time left");

  // An expiry result also reports a save and a done, stopped phase
  a_expiry_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_expired_r) |-> (out_save_r && out_done_r && !out_running_r))
    else $error("expiry result with inconsistent flags");

  // A reset request returns to the first work phase
  a_reset_req: assert property (@(posedge clk) disable iff (!rst_n)
    (process && s1_req_r == REQ_RESET) |=> (phase_r == PH_WORK && index_r == INDEX_W'(1)))
    else $error("reset request did not return to work 1");

  // Result register only loads while a request is being processed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_secs_r)))
    else $error("stalled result changed");

endmodule
